### rtl/blvd_pkg.sv
`default_nettype none

package blvd_pkg;

    localparam int VAL_W = 32;
    localparam int CMD_W = 3;
    localparam int ST_W  = 2;
    localparam int LEN_W = 5;

    typedef logic [LEN_W-1:0] t_len;
    typedef logic [CMD_W-1:0] t_cmd_code;
    typedef logic [ST_W-1:0]  t_status;
    typedef logic [1:0]       t_rd_sel;
    typedef logic [2:0]       t_idx_op;

    // request codes
    localparam t_cmd_code CMD_PUSH_FRONT = 3'd0;
    localparam t_cmd_code CMD_PUSH_BACK  = 3'd1;
    localparam t_cmd_code CMD_POP_FRONT  = 3'd2;
    localparam t_cmd_code CMD_POP_BACK   = 3'd3;
    localparam t_cmd_code CMD_DEL_FIRST  = 3'd4;
    localparam t_cmd_code CMD_DEL_LAST   = 3'd5;
    localparam t_cmd_code CMD_CLEAR      = 3'd6;

    // result status codes
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_EMPTY    = 2'd1;
    localparam t_status ST_NOTFOUND = 2'd2;
    localparam t_status ST_FULL     = 2'd3;

    // read address selection, as an offset from the head
    localparam t_rd_sel RD_HEAD = 2'd0;
    localparam t_rd_sel RD_TAIL = 2'd1;
    localparam t_rd_sel RD_IDX  = 2'd2;
    localparam t_rd_sel RD_IDXN = 2'd3;

    // walk index operations
    localparam t_idx_op IDX_HOLD  = 3'd0;
    localparam t_idx_op IDX_FIRST = 3'd1;
    localparam t_idx_op IDX_LAST  = 3'd2;
    localparam t_idx_op IDX_INC   = 3'd3;
    localparam t_idx_op IDX_DEC   = 3'd4;

    typedef struct packed {
        logic    ready;
        logic    accept;
        logic    push_front;
        logic    push_back;
        logic    pop_front;
        logic    pop_back;
        logic    clear;
        logic    dec_count;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_shift;
        t_idx_op idx_op;
        logic    load_out;
        t_status out_status;
        logic    out_use_rd;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd_code cmd;
        logic      empty;
        logic      full;
        logic      match;
        logic      at_end;
        logic      next_at_end;
        logic      at_zero;
        logic      out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/bounded_list_with_value_delete.sv
// Ordered list of up to DEPTH signed 32-bit values, kept in a circular store.
// Input channel: i_in_valid / o_in_stall with i_command and i_value; one
// request is taken at an edge where i_in_valid is high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall with o_status, o_value_out and
// o_length; every request gives exactly one result, in request order.
// Push, pop, clear and unused codes pass through S_EXEC and S_DONE before
// o_out_valid rises; the next request is taken only back in S_IDLE.
// Delete by value walks the store through its single read port: each entry
// compared passes through S_SRD and S_SCMP, then each entry behind the match
// is moved one place toward the head through S_MRD and S_MWR to close the
// gap. The first-match search walks from the head, the last-match search
// from the back; a delete that finds nothing reports ST_NOTFOUND.
// One request is worked on at a time; o_in_stall is low only while idle.
// A finished result waits in the output register while i_out_stall is high,
// and the block holds in its last step until that register is free.
// Reset (synchronous, active low) empties the list and drops any pending
// result; store contents are left as they are.

`default_nettype none

module bounded_list_with_value_delete #(
    parameter int DEPTH = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire [blvd_pkg::CMD_W-1:0]         i_command,
    input  wire signed [blvd_pkg::VAL_W-1:0]  i_value,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [blvd_pkg::ST_W-1:0]         o_status,
    output logic signed [blvd_pkg::VAL_W-1:0] o_value_out,
    output logic [blvd_pkg::LEN_W-1:0]        o_length
);

    blvd_pkg::t_dp_cmd w_cmd;
    blvd_pkg::t_dp_sts w_sts;

    blvd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    blvd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_command   (i_command),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_length    (o_length)
    );

    assign o_in_stall = !w_cmd.ready;

endmodule

`default_nettype wire

### rtl/blvd_dp.sv
`default_nettype none

module blvd_dp #(
    parameter int DEPTH = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire blvd_pkg::t_dp_cmd            i_cmd,
    output blvd_pkg::t_dp_sts                 o_sts,
    input  wire [blvd_pkg::CMD_W-1:0]         i_command,
    input  wire signed [blvd_pkg::VAL_W-1:0]  i_value,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [blvd_pkg::ST_W-1:0]         o_status,
    output logic signed [blvd_pkg::VAL_W-1:0] o_value_out,
    output logic [blvd_pkg::LEN_W-1:0]        o_length
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef logic [AW:0] t_wide;

    localparam t_wide DEPTH_W = t_wide'(DEPTH);

    logic [blvd_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic [blvd_pkg::VAL_W-1:0] r_rdata;
    logic [blvd_pkg::VAL_W-1:0] r_val;
    blvd_pkg::t_cmd_code        r_cmd;
    logic [AW-1:0]              r_head;
    logic [AW-1:0]              n_head;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic [AW-1:0]              r_idx;
    logic [AW-1:0]              n_idx;
    logic                       r_out_valid;
    blvd_pkg::t_status          r_status;
    logic [blvd_pkg::VAL_W-1:0] r_vout;
    blvd_pkg::t_len             r_len;

    t_wide         head_w;
    t_wide         count_w;
    t_wide         idx_w;
    t_wide         rd_off;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic          wr_en;
    logic          out_free;

    // fold an offset from the head back into the circular store
    function automatic logic [AW-1:0] wrap_addr(input t_wide s);
        t_wide t;
        t = (s >= DEPTH_W) ? s - DEPTH_W : s;
        return t[AW-1:0];
    endfunction

    assign head_w   = t_wide'(r_head);
    assign count_w  = t_wide'(r_count);
    assign idx_w    = t_wide'(r_idx);
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        unique case (i_cmd.rd_sel)
            blvd_pkg::RD_HEAD: rd_off = '0;
            blvd_pkg::RD_TAIL: rd_off = count_w - t_wide'(1);
            blvd_pkg::RD_IDX:  rd_off = idx_w;
            blvd_pkg::RD_IDXN: rd_off = idx_w + t_wide'(1);
            default:           rd_off = '0;
        endcase
        rd_addr = wrap_addr(head_w + rd_off);
    end

    always_comb begin
        wr_en = i_cmd.push_front || i_cmd.push_back || i_cmd.wr_shift;
        priority if (i_cmd.push_front) begin
            wr_addr = head_dec;
        end else if (i_cmd.push_back) begin
            wr_addr = wrap_addr(head_w + count_w);
        end else begin
            wr_addr = wrap_addr(head_w + idx_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.wr_shift ? r_rdata : r_val;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.push_front) begin
            n_head  = head_dec;
            n_count = r_count + CW'(1);
        end else if (i_cmd.push_back) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop_front) begin
            n_head  = head_inc;
            n_count = r_count - CW'(1);
        end else if (i_cmd.pop_back || i_cmd.dec_count) begin
            n_count = r_count - CW'(1);
        end else if (i_cmd.clear) begin
            n_count = '0;
        end
    end

    always_comb begin
        unique case (i_cmd.idx_op)
            blvd_pkg::IDX_HOLD:  n_idx = r_idx;
            blvd_pkg::IDX_FIRST: n_idx = '0;
            blvd_pkg::IDX_LAST:  n_idx = AW'(r_count - CW'(1));
            blvd_pkg::IDX_INC:   n_idx = r_idx + AW'(1);
            blvd_pkg::IDX_DEC:   n_idx = r_idx - AW'(1);
            default:             n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.accept) begin
            r_cmd <= i_command;
            r_val <= i_value;
        end
        if (i_cmd.load_out) begin
            r_status <= i_cmd.out_status;
            r_vout   <= i_cmd.out_use_rd ? r_rdata : '0;
            r_len    <= blvd_pkg::t_len'(r_count);
        end
    end

    always_comb begin
        o_sts.cmd         = r_cmd;
        o_sts.empty       = (r_count == '0);
        o_sts.full        = (r_count == CW'(DEPTH));
        o_sts.match       = (r_rdata == r_val);
        o_sts.at_end      = (idx_w + t_wide'(1) == count_w);
        o_sts.next_at_end = (idx_w + t_wide'(2) == count_w);
        o_sts.at_zero     = (r_idx == '0);
        o_sts.out_free    = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value_out = r_vout;
    assign o_length    = r_len;

endmodule

`default_nettype wire

### rtl/blvd_ctrl.sv
`default_nettype none

module blvd_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire blvd_pkg::t_dp_sts i_sts,
    output blvd_pkg::t_dp_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SRD  = 3'd2;
    localparam logic [2:0] S_SCMP = 3'd3;
    localparam logic [2:0] S_MRD  = 3'd4;
    localparam logic [2:0] S_MWR  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    blvd_pkg::t_status r_res;
    blvd_pkg::t_status n_res;
    logic              r_use_rd;
    logic              n_use_rd;
    logic              first;

    assign first = (i_sts.cmd == blvd_pkg::CMD_DEL_FIRST);

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_res    = r_res;
        n_use_rd = r_use_rd;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res    = blvd_pkg::ST_OK;
                n_use_rd = 1'b0;
                n_state  = S_DONE;
                unique case (i_sts.cmd)
                    blvd_pkg::CMD_PUSH_FRONT, blvd_pkg::CMD_PUSH_BACK: begin
                        if (i_sts.full) begin
                            n_res = blvd_pkg::ST_FULL;
                        end else begin
                            o_cmd.push_front = (i_sts.cmd == blvd_pkg::CMD_PUSH_FRONT);
                            o_cmd.push_back  = (i_sts.cmd == blvd_pkg::CMD_PUSH_BACK);
                        end
                    end
                    blvd_pkg::CMD_POP_FRONT, blvd_pkg::CMD_POP_BACK: begin
                        if (i_sts.empty) begin
                            n_res = blvd_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            if (i_sts.cmd == blvd_pkg::CMD_POP_FRONT) begin
                                o_cmd.rd_sel    = blvd_pkg::RD_HEAD;
                                o_cmd.pop_front = 1'b1;
                            end else begin
                                o_cmd.rd_sel   = blvd_pkg::RD_TAIL;
                                o_cmd.pop_back = 1'b1;
                            end
                            n_use_rd = 1'b1;
                        end
                    end
                    blvd_pkg::CMD_DEL_FIRST, blvd_pkg::CMD_DEL_LAST: begin
                        if (i_sts.empty) begin
                            n_res = blvd_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.idx_op = first ? blvd_pkg::IDX_FIRST : blvd_pkg::IDX_LAST;
                            n_state      = S_SRD;
                        end
                    end
                    blvd_pkg::CMD_CLEAR: begin
                        if (i_sts.empty) begin
                            n_res = blvd_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.clear = 1'b1;
                        end
                    end
                    default: begin
                        // unused code: report ok, touch nothing
                    end
                endcase
            end
            S_SRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = blvd_pkg::RD_IDX;
                n_state      = S_SCMP;
            end
            S_SCMP: begin
                if (i_sts.match) begin
                    if (i_sts.at_end) begin
                        // last entry matched: nothing to close up
                        o_cmd.dec_count = 1'b1;
                        n_state         = S_DONE;
                    end else begin
                        n_state = S_MRD;
                    end
                end else if (first ? i_sts.at_end : i_sts.at_zero) begin
                    n_res   = blvd_pkg::ST_NOTFOUND;
                    n_state = S_DONE;
                end else begin
                    o_cmd.idx_op = first ? blvd_pkg::IDX_INC : blvd_pkg::IDX_DEC;
                    n_state      = S_SRD;
                end
            end
            S_MRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = blvd_pkg::RD_IDXN;
                n_state      = S_MWR;
            end
            S_MWR: begin
                o_cmd.wr_shift = 1'b1;
                if (i_sts.next_at_end) begin
                    o_cmd.dec_count = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.idx_op = blvd_pkg::IDX_INC;
                    n_state      = S_MRD;
                end
            end
            S_DONE: begin
                o_cmd.out_status = r_res;
                o_cmd.out_use_rd = r_use_rd;
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res    <= n_res;
        r_use_rd <= n_use_rd;
    end

endmodule

`default_nettype wire

### rtl/blvd_chk.sv
`default_nettype none

module blvd_chk #(
    parameter int DEPTH = 16
) (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_in_valid,
    input wire                         o_in_stall,
    input wire                         o_out_valid,
    input wire                         i_out_stall,
    input wire [blvd_pkg::ST_W-1:0]    o_status,
    input wire [blvd_pkg::VAL_W-1:0]   o_value_out,
    input wire [blvd_pkg::LEN_W-1:0]   o_length
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_value_out) && $stable(o_length))
        else $error("result changed while stalled");

    // a refused push only happens on a full list
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == blvd_pkg::ST_FULL
            |-> o_length == blvd_pkg::t_len'(DEPTH))
        else $error("full status with list not full");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == blvd_pkg::ST_EMPTY |-> o_length == '0)
        else $error("empty status with entries left");

    // only a successful pop returns data
    a_vout_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_value_out != '0 |-> o_status == blvd_pkg::ST_OK)
        else $error("value returned with failing status");

    // one request at a time: take nothing right after an acceptance
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while previous still in progress");

endmodule

bind bounded_list_with_value_delete blvd_chk #(
    .DEPTH (DEPTH)
) u_blvd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_value_out (o_value_out),
    .o_length    (o_length)
);

`default_nettype wire
